// ===== rtl/dlmb_pkg.sv =====
package dlmb_pkg;

    // default sizes of the weight memory
    localparam int MAX_INNER_DEF = 1024;
    localparam int MAX_OUT_DEF   = 64;

    // field widths
    localparam int CMD_W   = 2;
    localparam int INNER_W = 10;
    localparam int COL_W   = 6;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 32;
    localparam int ACC_W   = 48;
    localparam int LEN_W   = 11;
    localparam int OLEN_W  = 7;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 1;

    // bias is Q3.12, the accumulators carry 24 fraction bits
    localparam int FRAC_SHIFT = 12;

    // commands
    localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACT    = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_INNER_LEN = 1'b0;
    localparam logic [IDX_W-1:0] REG_OUT_LEN   = 1'b1;

    // register reset values
    localparam logic [LEN_W-1:0]  INNER_LEN_RST = 11'd1024;
    localparam logic [OLEN_W-1:0] OUT_LEN_RST   = 7'd10;

    // strobes shared by every column cell
    typedef struct packed {
        logic mult_en;
        logic acc_en;
        logic finish;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== rtl/dlmb_if.sv =====
interface dlmb_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [dlmb_pkg::CMD_W-1:0]           cmd;
    logic [dlmb_pkg::INNER_W-1:0]         inner_index;
    logic [dlmb_pkg::COL_W-1:0]           out_index;
    logic signed [dlmb_pkg::VAL_W-1:0]    value;

    modport source (output valid, cmd, inner_index, out_index, value, input ready);
    modport sink   (input valid, cmd, inner_index, out_index, value, output ready);
endinterface

interface dlmb_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [dlmb_pkg::COL_W-1:0]           out_col;
    logic signed [dlmb_pkg::ACC_W-1:0]    out_value;
    logic                                 last_of_row;

    modport source (output valid, out_col, out_value, last_of_row, input ready);
    modport sink   (input valid, out_col, out_value, last_of_row, output ready);
endinterface

// ===== rtl/dlmb_cell.sv =====
module dlmb_cell #(
    parameter int MAX_INNER = dlmb_pkg::MAX_INNER_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dlmb_pkg::cell_ctrl_t                ctrl,
    input  logic                                wr_en,
    input  logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] wr_addr,
    input  logic                                bias_wr,
    input  logic signed [dlmb_pkg::VAL_W-1:0]   wdata,
    input  logic                                rd_en,
    input  logic [((MAX_INNER > 1) ? $clog2(MAX_INNER) : 1)-1:0] rd_addr,
    input  logic signed [dlmb_pkg::VAL_W-1:0]   act,
    input  logic signed [dlmb_pkg::ACC_W-1:0]   shift_in,
    output logic signed [dlmb_pkg::ACC_W-1:0]   shift_out
);

    logic signed [dlmb_pkg::VAL_W-1:0]  mem [MAX_INNER];
    logic signed [dlmb_pkg::VAL_W-1:0]  w_reg;
    logic signed [dlmb_pkg::VAL_W-1:0]  bias_reg;
    logic signed [dlmb_pkg::PROD_W-1:0] prod_reg;
    logic signed [dlmb_pkg::ACC_W-1:0]  acc_reg;
    logic signed [dlmb_pkg::ACC_W-1:0]  acc_next;
    logic signed [dlmb_pkg::ACC_W-1:0]  out_reg;
    logic signed [dlmb_pkg::ACC_W-1:0]  result;

    // weight column of this cell, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wdata;
        end
        if (rd_en)
        begin
            w_reg <= mem[rd_addr];
        end
    end

    // bias and product registers
    always_ff @(posedge clk)
    begin
        if (bias_wr)
        begin
            bias_reg <= wdata;
        end
        if (ctrl.mult_en)
        begin
            prod_reg <= act * w_reg;
        end
    end

    // accumulate, and the row total with bias
    always_comb
    begin
        acc_next = acc_reg + dlmb_pkg::ACC_W'(prod_reg);
        result   = acc_next + (dlmb_pkg::ACC_W'(bias_reg) <<< dlmb_pkg::FRAC_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.finish)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // result stage of the drain chain
    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            out_reg <= result;
        end
        else if (ctrl.shift)
        begin
            out_reg <= shift_in;
        end
    end

    assign shift_out = out_reg;

endmodule

// ===== rtl/dense_layer_matmul_bias.sv =====
// Weight-stationary dense layer, D = A*B + C, one row of A at a time. One cell per output
// column holds that column's weights in a local memory of MAX_INNER entries, its bias and a
// 48-bit accumulator. Weight writes, bias writes and activation elements share one input
// channel, so a row of inner_len elements streams in at one item per clock while din.ready
// is high. The element that completes a row passes through the weight read and multiplier
// stages; then out_len results leave one per cycle, as dout.ready allows, through a shift
// chain along the cells, column 0 first, the last one flagged by last_of_row. No item is
// taken from the row's final element until its last result has left.
// Weights and biases must be written before they are used; there is no clearing pass.
module dense_layer_matmul_bias #(
    parameter int MAX_INNER = dlmb_pkg::MAX_INNER_DEF,
    parameter int MAX_OUT   = dlmb_pkg::MAX_OUT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    dlmb_in_if.sink                       din,
    dlmb_out_if.source                    dout,
    input  logic                          cfg_we,
    input  logic [dlmb_pkg::IDX_W-1:0]    cfg_index,
    input  logic [dlmb_pkg::CFG_W-1:0]    cfg_data
);

    localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int PW = $clog2(MAX_INNER + 1);

    logic [dlmb_pkg::LEN_W-1:0]        inner_len_reg;
    logic [dlmb_pkg::OLEN_W-1:0]       out_len_reg;
    logic [PW-1:0]                     pos_reg;
    logic [PW-1:0]                     pos_next;
    logic [PW:0]                       pos_inc;
    logic [PW-1:0]                     row_len;
    logic                              row_last;
    logic                              busy_reg;
    logic                              v1_reg;
    logic                              l1_reg;
    logic                              v2_reg;
    logic                              l2_reg;
    logic                              drain_reg;
    logic [dlmb_pkg::COL_W-1:0]        idx_reg;
    logic [dlmb_pkg::COL_W-1:0]        cols_m1_reg;
    logic [dlmb_pkg::COL_W-1:0]        cols_m1;
    logic signed [dlmb_pkg::VAL_W-1:0] act_reg;
    logic                              in_acc;
    logic                              act_acc;
    logic                              wgt_acc;
    logic                              bias_acc;
    logic                              out_acc;
    logic [IW-1:0]                     wr_addr;
    dlmb_pkg::cell_ctrl_t              ctrl;
    logic signed [dlmb_pkg::ACC_W-1:0] chain [MAX_OUT+1];

    // handshakes
    assign din.ready = !busy_reg;
    assign in_acc    = din.valid && !busy_reg;
    assign act_acc   = in_acc && (din.cmd == dlmb_pkg::CMD_ACT);
    assign wgt_acc   = in_acc && (din.cmd == dlmb_pkg::CMD_WEIGHT)
                       && (32'(din.inner_index) < MAX_INNER);
    assign bias_acc  = in_acc && (din.cmd == dlmb_pkg::CMD_BIAS);
    assign out_acc   = drain_reg && dout.ready;
    assign wr_addr   = IW'(din.inner_index);

    // row length and column count, saturated to the array size, a zero taken as one
    always_comb
    begin
        if (inner_len_reg == '0)
        begin
            row_len = PW'(1);
        end
        else if (32'(inner_len_reg) > MAX_INNER)
        begin
            row_len = PW'(MAX_INNER);
        end
        else
        begin
            row_len = PW'(inner_len_reg);
        end

        if (out_len_reg == '0)
        begin
            cols_m1 = '0;
        end
        else if (32'(out_len_reg) > MAX_OUT)
        begin
            cols_m1 = dlmb_pkg::COL_W'(MAX_OUT - 1);
        end
        else
        begin
            cols_m1 = dlmb_pkg::COL_W'(out_len_reg - dlmb_pkg::OLEN_W'(1));
        end
    end

    // element position along the row
    always_comb
    begin
        pos_inc  = {1'b0, pos_reg} + (PW+1)'(1);
        row_last = (pos_inc >= {1'b0, row_len});
        pos_next = row_last ? '0 : pos_inc[PW-1:0];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_len_reg <= dlmb_pkg::INNER_LEN_RST;
            out_len_reg   <= dlmb_pkg::OUT_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dlmb_pkg::REG_INNER_LEN: inner_len_reg <= cfg_data[dlmb_pkg::LEN_W-1:0];
                dlmb_pkg::REG_OUT_LEN:   out_len_reg   <= cfg_data[dlmb_pkg::OLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // activation register
    always_ff @(posedge clk)
    begin
        if (act_acc)
        begin
            act_reg <= din.value;
        end
    end

    // row control, pipeline flags and result drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            busy_reg    <= 1'b0;
            v1_reg      <= 1'b0;
            l1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            l2_reg      <= 1'b0;
            drain_reg   <= 1'b0;
            idx_reg     <= '0;
            cols_m1_reg <= '0;
        end
        else
        begin
            v1_reg <= act_acc;
            l1_reg <= act_acc && row_last;
            v2_reg <= v1_reg;
            l2_reg <= l1_reg;
            if (act_acc)
            begin
                pos_reg <= pos_next;
                if (row_last)
                begin
                    busy_reg <= 1'b1;
                end
            end
            if (v2_reg && l2_reg)
            begin
                drain_reg   <= 1'b1;
                idx_reg     <= '0;
                cols_m1_reg <= cols_m1;
            end
            else if (out_acc)
            begin
                if (idx_reg == cols_m1_reg)
                begin
                    drain_reg <= 1'b0;
                    busy_reg  <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + dlmb_pkg::COL_W'(1);
                end
            end
        end
    end

    // strobes to the cells
    always_comb
    begin
        ctrl.mult_en = v1_reg;
        ctrl.acc_en  = v2_reg;
        ctrl.finish  = v2_reg && l2_reg;
        ctrl.shift   = out_acc;
    end

    // one cell per output column, drained towards column 0
    assign chain[MAX_OUT] = '0;

    for (genvar i = 0; i < MAX_OUT; i++)
    begin : g_col
        dlmb_cell #(
            .MAX_INNER (MAX_INNER)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .wr_en     (wgt_acc && (32'(din.out_index) == i)),
            .wr_addr   (wr_addr),
            .bias_wr   (bias_acc && (32'(din.out_index) == i)),
            .wdata     (din.value),
            .rd_en     (act_acc),
            .rd_addr   (pos_reg[IW-1:0]),
            .act       (act_reg),
            .shift_in  (chain[i+1]),
            .shift_out (chain[i])
        );
    end

    // result channel
    assign dout.valid       = drain_reg;
    assign dout.out_col     = idx_reg;
    assign dout.out_value   = chain[0];
    assign dout.last_of_row = (idx_reg == cols_m1_reg);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import dlmb_pkg::*;

    // command code that the block drops
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_GAP       = 13;

    // weight rows filled for the first PRE_COLS columns, plus row 0 of all other columns
    localparam int PRE_ROWS = 6;
    localparam int PRE_COLS = 16;

    typedef struct {
        logic [COL_W-1:0] col;
        logic [ACC_W-1:0] value;
        logic             last;
    } column_result_t;

    logic clk;
    logic rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    dlmb_in_if  din_if ();
    dlmb_out_if dout_if ();

    dense_layer_matmul_bias u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din_if),
        .dout      (dout_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the layer: stores, column sums, row position and registers
    logic signed [VAL_W-1:0] weight_mem [MAX_INNER_DEF][MAX_OUT_DEF];
    logic signed [VAL_W-1:0] bias_mem [MAX_OUT_DEF];
    longint                  col_sum [MAX_OUT_DEF];
    int                      elem_pos;
    logic [LEN_W-1:0]        inner_len_q;
    logic [OLEN_W-1:0]       out_len_q;

    column_result_t due_columns[$];
    int             fault_count;
    int             out_stall;
    bit             calm;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int clamp_len(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // update the shadow for one accepted item and queue the columns it completes
    task automatic absorb_item(input logic [CMD_W-1:0] op, input logic [INNER_W-1:0] k_idx,
                               input logic [COL_W-1:0] m_idx,
                               input logic signed [VAL_W-1:0] val);
        int             row_len;
        int             cols;
        column_result_t res;
        case (op)
            CMD_WEIGHT: weight_mem[k_idx][m_idx] = val;
            CMD_BIAS:   bias_mem[m_idx] = val;
            CMD_ACT:
            begin
                for (int c = 0; c < MAX_OUT_DEF; c++)
                    col_sum[c] += longint'(val) * longint'(weight_mem[elem_pos][c]);
                elem_pos++;
                row_len = clamp_len(inner_len_q, MAX_INNER_DEF);
                if (elem_pos >= row_len)
                begin
                    cols = clamp_len(out_len_q, MAX_OUT_DEF);
                    for (int c = 0; c < cols; c++)
                    begin
                        res.col   = COL_W'(c);
                        res.value = ACC_W'(col_sum[c] + (longint'(bias_mem[c]) <<< FRAC_SHIFT));
                        res.last  = (c == cols - 1);
                        due_columns.push_back(res);
                    end
                    for (int c = 0; c < MAX_OUT_DEF; c++)
                        col_sum[c] = 0;
                    elem_pos = 0;
                end
            end
            default: ;
        endcase
    endtask

    // send one item, called and returning at a falling edge
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [INNER_W-1:0] k_idx,
                             input logic [COL_W-1:0] m_idx,
                             input logic signed [VAL_W-1:0] val);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            din_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        din_if.valid       <= 1'b1;
        din_if.cmd         <= op;
        din_if.inner_index <= k_idx;
        din_if.out_index   <= m_idx;
        din_if.value       <= val;
        do
            @(posedge clk);
        while (!din_if.ready);
        absorb_item(op, k_idx, m_idx, val);
        @(negedge clk);
    endtask

    // hold off until every queued column has arrived and the pipeline has drained
    task automatic wait_idle();
        din_if.valid <= 1'b0;
        while (due_columns.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wait_idle();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_INNER_LEN: inner_len_q = data[LEN_W-1:0];
            REG_OUT_LEN:   out_len_q = data[OLEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_acts(input int count);
        for (int i = 0; i < count; i++)
            send_item(CMD_ACT, INNER_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
    endtask

    // receiver stalls, one draw per accepted column
    initial
    begin
        dout_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (out_stall > 0)
            begin
                dout_if.ready <= 1'b0;
                out_stall = out_stall - 1;
            end
            else
                dout_if.ready <= 1'b1;
        end
    end

    // column checker
    always @(posedge clk)
    begin
        column_result_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            out_stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (due_columns.size() == 0)
            begin
                fault_count++;
                $display("%0t: unexpected column, expected none, got col %0d value %0d",
                         $time, dout_if.out_col, dout_if.out_value);
            end
            else
            begin
                want = due_columns.pop_front();
                if (dout_if.out_col !== want.col)
                begin
                    fault_count++;
                    $display("%0t: out_col expected %0d, got %0d",
                             $time, want.col, dout_if.out_col);
                end
                if (dout_if.out_value !== want.value)
                begin
                    fault_count++;
                    $display("%0t: out_value col %0d expected %0d, got %0d", $time,
                             want.col, $signed(want.value), dout_if.out_value);
                end
                if (dout_if.last_of_row !== want.last)
                begin
                    fault_count++;
                    $display("%0t: last_of_row col %0d expected %0b, got %0b",
                             $time, want.col, want.last, dout_if.last_of_row);
                end
            end
        end
    end

    // fill the weights and biases that later rows read
    task automatic test_preload();
        calm = 1'b1;
        for (int k = 0; k < PRE_ROWS; k++)
            for (int m = 0; m < PRE_COLS; m++)
                send_item(CMD_WEIGHT, INNER_W'(k), COL_W'(m), VAL_W'($urandom));
        for (int m = PRE_COLS; m < MAX_OUT_DEF; m++)
            send_item(CMD_WEIGHT, '0, COL_W'(m), VAL_W'($urandom));
        for (int m = 0; m < MAX_OUT_DEF; m++)
            send_item(CMD_BIAS, INNER_W'($urandom), COL_W'(m), VAL_W'($urandom));
        calm = 1'b0;
    endtask

    // long row length and ten columns after reset, row closed by a shorter length
    task automatic test_reset_lengths();
        send_acts(4);
        write_reg(REG_INNER_LEN, 11'd6);
        send_acts(2);
    endtask

    // extreme values, one-element rows of all 64 columns, dropped command
    task automatic test_extremes();
        write_reg(REG_OUT_LEN, '1);
        write_reg(REG_INNER_LEN, '0);
        send_item(CMD_WEIGHT, '0, '0, 16'sh8000);
        send_item(CMD_WEIGHT, '0, '1, 16'sh7fff);
        send_item(CMD_WEIGHT, '1, '1, 16'sh8000);
        send_item(CMD_BIAS, '0, '0, 16'sh8000);
        send_item(CMD_BIAS, '1, '1, 16'sh7fff);
        send_item(CMD_UNUSED, '1, '1, '1);
        send_item(CMD_ACT, '0, '0, 16'sh8000);
        send_item(CMD_ACT, '1, '1, 16'sh7fff);
        send_item(CMD_ACT, '0, '0, '0);
        send_item(CMD_UNUSED, '0, '0, '0);
        send_item(CMD_ACT, '1, '1, '1);
    endtask

    // row length and column count changed while a row is part way through
    task automatic test_mid_row_change();
        write_reg(REG_INNER_LEN, 11'd8);
        write_reg(REG_OUT_LEN, 11'd5);
        send_acts(5);
        // position already past the new length, so the next element closes the row
        write_reg(REG_INNER_LEN, 11'd3);
        send_acts(1);
        send_acts(2);
        write_reg(REG_OUT_LEN, 11'd12);
        write_reg(REG_INNER_LEN, 11'd4);
        send_acts(2);
    endtask

    // oversized row length does not close early, zero and oversized lengths saturate
    task automatic test_length_clamps();
        write_reg(REG_OUT_LEN, 11'd16);
        write_reg(REG_INNER_LEN, '1);
        send_acts(3);
        write_reg(REG_INNER_LEN, 11'd4);
        send_acts(1);
        write_reg(REG_INNER_LEN, '0);
        write_reg(REG_OUT_LEN, 11'd65);
        send_acts(2);
        write_reg(REG_OUT_LEN, '0);
        send_acts(2);
    endtask

    // short rows under random settings, with occasional writes and dropped commands
    task automatic test_random_rows();
        int pick;
        int sent;
        for (int phase = 0; phase < 5; phase++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_reg(REG_INNER_LEN, CFG_W'(0));
            else
                write_reg(REG_INNER_LEN, CFG_W'($urandom_range(1, 4)));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_reg(REG_OUT_LEN, CFG_W'(0));
            else
                write_reg(REG_OUT_LEN, CFG_W'($urandom_range(1, PRE_COLS)));
            calm = ($urandom_range(0, 4) == 0);
            sent = 0;
            while (sent < 12)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_item(CMD_ACT, INNER_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
                else if (pick < 82)
                    send_item(CMD_WEIGHT, INNER_W'($urandom), COL_W'($urandom),
                              VAL_W'($urandom));
                else if (pick < 95)
                    send_item(CMD_BIAS, INNER_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
                else
                    send_item(CMD_UNUSED, INNER_W'($urandom), COL_W'($urandom),
                              VAL_W'($urandom));
                if (pick < 95)
                    sent++;
            end
        end
        calm = 1'b0;
    endtask

    // sequence of tests
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        din_if.valid       = 1'b0;
        din_if.cmd         = '0;
        din_if.inner_index = '0;
        din_if.out_index   = '0;
        din_if.value       = '0;
        out_stall          = 0;
        calm               = 1'b0;
        fault_count        = 0;
        elem_pos           = 0;
        inner_len_q        = INNER_LEN_RST;
        out_len_q          = OUT_LEN_RST;
        for (int c = 0; c < MAX_OUT_DEF; c++)
            col_sum[c] = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_preload();
        test_reset_lengths();
        test_extremes();
        test_mid_row_change();
        test_length_clamps();
        test_random_rows();

        wait_idle();
        repeat (4 * SETTLE_CYCLES) @(negedge clk);
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
